[src/tksel_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the top-k index selector.
// No dependencies.
package tksel_pkg;

    localparam int SCORE_W        = 32;
    localparam int IDX_W          = 6;
    localparam int KEEP_W         = 7;
    localparam int WIN_W          = 7;
    localparam int SUM_W          = WIN_W + 1;
    localparam int MAX_SCORES_DEF = 64;
    localparam int CFG_IDX_W      = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_WINDOW   = 1'd1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          index;
    } tksel_entry_t;

endpackage

[src/topk_index_select_with_windows_unit.sv]
`timescale 1ns / 1ps
// Top level of the top-k block index selector: control and the cell chain.
// Depends on tksel_pkg and tksel_cell.
//
// Scores are taken one per cycle while busy is low; each goes straight into
// a chain of MAX_SCORES cells kept in descending score order. The request
// with last_score high ends the set and busy rises the next cycle. Results
// then come on strobe, in the cycle after they are chosen, and cannot be
// held off: leading window, trailing window, then the middle picks, read
// off the head of the chain as it shifts up one cell a cycle. Window
// entries met while scanning are skipped. If keep_count is zero or the
// windows or keep_count cover the whole set, all indexes come in order
// instead. The last result is flagged by last_index. Configuration writes
// are always ready.
module topk_index_select_with_windows_unit #(
    parameter int MAX_SCORES = tksel_pkg::MAX_SCORES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [tksel_pkg::SCORE_W-1:0] score,
    input  logic [tksel_pkg::KEEP_W-1:0]     keep_count,
    input  logic                             last_score,
    output logic                             strobe,
    output logic [tksel_pkg::IDX_W-1:0]      block_index,
    output logic                             last_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tksel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tksel_pkg::WIN_W-1:0]      cfg_data
);
    import tksel_pkg::*;

    localparam int CNT_W = $clog2(MAX_SCORES + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_SCORES);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_ALL  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_MID  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [KEEP_W-1:0] n_reg, n_next;
    logic [KEEP_W-1:0] hi_reg, hi_next;
    logic [KEEP_W-1:0] total_reg, total_next;
    logic [KEEP_W-1:0] emitted_reg, emitted_next;
    logic [KEEP_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0]  sw_reg, ew_reg;
    logic              strobe_reg;
    logic [IDX_W-1:0]  block_index_reg;
    logic              last_index_reg;

    logic              accept;
    logic              load_en;
    logic              shift;
    logic              emit;
    logic              last_emit;
    logic [IDX_W-1:0]  emit_idx;
    logic [CNT_W-1:0]  n_new;
    logic [SUM_W-1:0]  win_sum;
    logic              all_case;
    logic              in_range;

    tksel_entry_t      in_entry;
    tksel_entry_t      ent [MAX_SCORES];
    logic              gt  [MAX_SCORES];

    assign accept   = start && !busy;
    assign load_en  = accept && (count_reg < MAX_C);
    assign busy     = (state_reg != S_LOAD);
    assign cfg_ready = 1'b1;

    assign in_entry.score = score;
    assign in_entry.index = IDX_W'(count_reg);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SCORES; gi++)
        begin : g_cell
            tksel_cell u_cell (
                .clk        (clk),
                .load       (load_en),
                .shift      (shift),
                .occ        (CNT_W'(gi) < count_reg),
                .in_entry   (in_entry),
                .prev_gt    ((gi == 0) ? 1'b0 : gt[(gi == 0) ? 0 : gi - 1]),
                .prev_entry (ent[(gi == 0) ? 0 : gi - 1]),
                .next_entry (ent[(gi == MAX_SCORES - 1) ? gi : gi + 1]),
                .entry      (ent[gi]),
                .gt         (gt[gi])
            );
        end
    endgenerate

    // set size and case selection at the last score
    assign n_new    = count_reg + CNT_W'(count_reg < MAX_C);
    assign win_sum  = SUM_W'(sw_reg) + SUM_W'(ew_reg);
    assign all_case = (win_sum >= SUM_W'(n_new)) || (SUM_W'(keep_count) >= SUM_W'(n_new))
                      || (keep_count == '0);
    assign in_range = ({1'b0, ent[0].index} >= sw_reg) && ({1'b0, ent[0].index} < hi_reg);
    assign last_emit = ((emitted_reg + KEEP_W'(1)) == total_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        hi_next      = hi_reg;
        total_next   = total_reg;
        emitted_next = emitted_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        emit_idx     = IDX_W'(cnt_reg);
        shift        = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (load_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_score)
                    begin
                        count_next   = '0;
                        n_next       = KEEP_W'(n_new);
                        hi_next      = KEEP_W'(n_new) - ew_reg;
                        emitted_next = '0;
                        cnt_next     = '0;
                        if (all_case)
                        begin
                            total_next = KEEP_W'(n_new);
                            state_next = S_ALL;
                        end
                        else
                        begin
                            total_next = (SUM_W'(keep_count) > win_sum) ? keep_count
                                                                        : KEEP_W'(win_sum);
                            if (sw_reg != '0)
                            begin
                                state_next = S_HEAD;
                            end
                            else if (ew_reg != '0)
                            begin
                                state_next = S_TAIL;
                                cnt_next   = KEEP_W'(n_new) - ew_reg;
                            end
                            else
                            begin
                                state_next = S_MID;
                            end
                        end
                    end
                end
            end
            S_ALL:
            begin
                emit     = 1'b1;
                cnt_next = cnt_reg + KEEP_W'(1);
                if (last_emit)
                begin
                    state_next = S_LOAD;
                end
            end
            S_HEAD:
            begin
                emit     = 1'b1;
                cnt_next = cnt_reg + KEEP_W'(1);
                if (last_emit)
                begin
                    state_next = S_LOAD;
                end
                else if ((cnt_reg + KEEP_W'(1)) == sw_reg)
                begin
                    if (ew_reg != '0)
                    begin
                        state_next = S_TAIL;
                        cnt_next   = hi_reg;
                    end
                    else
                    begin
                        state_next = S_MID;
                    end
                end
            end
            S_TAIL:
            begin
                emit     = 1'b1;
                cnt_next = cnt_reg + KEEP_W'(1);
                if (last_emit)
                begin
                    state_next = S_LOAD;
                end
                else if ((cnt_reg + KEEP_W'(1)) == n_reg)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                // head of the chain is the best remaining score
                shift    = 1'b1;
                emit     = in_range;
                emit_idx = ent[0].index;
                if (in_range && last_emit)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (emit)
        begin
            emitted_next = emitted_reg + KEEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            sw_reg      <= '0;
            ew_reg      <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= emit;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_START_WINDOW: sw_reg <= cfg_data;
                    REG_END_WINDOW:   ew_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        hi_reg          <= hi_next;
        total_reg       <= total_next;
        emitted_reg     <= emitted_next;
        cnt_reg         <= cnt_next;
        block_index_reg <= emit_idx;
        last_index_reg  <= emit && last_emit;
    end

    assign strobe      = strobe_reg;
    assign block_index = block_index_reg;
    assign last_index  = strobe_reg && last_index_reg;

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_index |-> strobe)
        else $error("last_index without strobe");

    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_index) |=> !strobe)
        else $error("result after the final one of a run");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("score count beyond chain length");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (emitted_reg < total_reg))
        else $error("emission ran past its total");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |=> ($past(count_reg) == count_reg))
        else $error("score count moved while emitting");

endmodule

[src/tksel_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorted insertion chain: holds one score and its index.
// Depends on tksel_pkg.
module tksel_cell (
    input  logic                 clk,
    input  logic                 load,
    input  logic                 shift,
    input  logic                 occ,
    input  tksel_pkg::tksel_entry_t in_entry,
    input  logic                 prev_gt,
    input  tksel_pkg::tksel_entry_t prev_entry,
    input  tksel_pkg::tksel_entry_t next_entry,
    output tksel_pkg::tksel_entry_t entry,
    output logic                 gt
);
    import tksel_pkg::*;

    tksel_entry_t entry_reg;
    tksel_entry_t entry_next;

    // strict compare: equal scores stay behind the older, lower index
    assign gt    = occ ? (in_entry.score > entry_reg.score) : 1'b1;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
        begin
            if (gt && !prev_gt)
            begin
                entry_next = in_entry;
            end
            else if (prev_gt)
            begin
                entry_next = prev_entry;
            end
        end
        else if (shift)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
